// ===== src/pcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse channel sweep control package
// Item types, register indexes and constants shared by the channel control.
// ----------------------------------------------------------------------------
package pcsc_pkg;

    localparam int unsigned CfgIdxWidth  = 3;
    localparam int unsigned CfgDataWidth = 11;
    localparam int unsigned StepWidth    = 8;
    localparam int unsigned PaceWidth    = 3;
    localparam int unsigned PeriodWidth  = 11;

    localparam logic [7:0] DacMask = 8'hf8;
    localparam logic [5:0] LengthMax = 6'd63;
    localparam logic [3:0] VolumeMax = 4'd15;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_SWEEP       = 3'd0,
        REG_DUTY_LENGTH = 3'd1,
        REG_ENVELOPE    = 3'd2,
        REG_PERIOD      = 3'd3,
        REG_LENGTH_EN   = 3'd4,
        REG_POWER       = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                 trigger;
        logic                 length_tick;
        logic                 envelope_tick;
        logic                 sweep_tick;
        logic [StepWidth-1:0] envelope_step;
        logic [StepWidth-1:0] sweep_step;
    } t_in_item;

    typedef struct packed {
        logic                   active;
        logic [3:0]             volume;
        logic [PeriodWidth-1:0] period;
        logic [2:0]             duty_eighths;
        logic [5:0]             length_count;
    } t_out_item;

    function automatic logic [2:0] duty_eighths_of(input logic [1:0] code);
        logic [2:0] eighths;
        unique case (code)
            2'd0: eighths = 3'd1;
            2'd1: eighths = 3'd2;
            2'd2: eighths = 3'd4;
            2'd3: eighths = 3'd6;
            default: eighths = 3'd1;
        endcase
        return eighths;
    endfunction

endpackage

// ===== src/pulse_channel_sweep_control.sv =====
// ----------------------------------------------------------------------------
// Pulse channel sweep control
// An accepted item passes envelope division and apply, then sweep division and
// apply; the divisions are two passes of one shared bit-serial remainder unit
// (envelope pace, then sweep pace). No new item is taken until the result is out.
// A finished result waits in an output register while the next item is taken.
// Reset (synchronous, active low) clears the settings, channel state and output.
// ----------------------------------------------------------------------------
module pulse_channel_sweep_control
    import pcsc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [CfgDataWidth-1:0] i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  t_in_item                i_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output t_out_item               o_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENV_DIV,
        S_ENV_APPLY,
        S_SWP_DIV,
        S_SWP_APPLY,
        S_OUT
    } t_state;

    t_state r_state;

    logic [6:0]             r_sweep_reg;
    logic [7:0]             r_duty_length_reg;
    logic [7:0]             r_envelope_reg;
    logic [PeriodWidth-1:0] r_period_reg;
    logic                   r_length_enable;
    logic                   r_power_on;

    logic [3:0]             r_volume;
    logic [2:0]             r_env_pace;
    logic                   r_env_up;
    logic [2:0]             r_duty;
    logic [5:0]             r_length;
    logic                   r_running;
    logic [PeriodWidth-1:0] r_period;

    logic                   r_work;
    t_in_item               r_item;
    t_out_item              r_out;
    logic                   r_out_valid;

    logic [StepWidth-1:0]   r_dvd;
    logic [PaceWidth-1:0]   r_div;
    logic [PaceWidth-1:0]   r_rem;
    logic [2:0]             r_cnt;

    logic                   n_accept;
    logic                   n_dac_on;
    logic [PaceWidth:0]     n_trial;
    logic [PaceWidth:0]     n_trial_sub;
    logic                   n_ge;
    logic [PaceWidth-1:0]   n_rem;
    logic [PeriodWidth-1:0] n_delta;
    logic [PeriodWidth:0]   n_sum;
    logic                   n_running;
    logic [5:0]             n_length;
    logic [2:0]             n_pace;

    assign o_stall  = (r_state != S_IDLE);
    assign n_accept = i_valid && !o_stall;
    assign n_dac_on = (r_envelope_reg & DacMask) != 8'd0;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    assign n_trial     = {r_rem, r_dvd[StepWidth-1]};
    assign n_ge        = n_trial >= {1'b0, r_div};
    assign n_trial_sub = n_trial - {1'b0, r_div};
    assign n_rem       = n_ge ? n_trial_sub[PaceWidth-1:0] : n_trial[PaceWidth-1:0];

    assign n_delta = r_period >> r_sweep_reg[2:0];
    assign n_sum   = {1'b0, r_period} + {1'b0, n_delta};

    // Trigger and length handling, applied in the accepting cycle.
    always_comb begin
        n_running = r_running;
        n_length  = r_length;
        n_pace    = r_env_pace;
        if (i_data.trigger) begin
            n_running = 1'b1;
            n_length  = r_duty_length_reg[5:0];
            n_pace    = r_envelope_reg[2:0];
        end
        if (r_length_enable && i_data.length_tick) begin
            if (n_length < LengthMax) begin
                n_length = n_length + 6'd1;
            end else begin
                n_running = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_sweep_reg       <= '0;
            r_duty_length_reg <= '0;
            r_envelope_reg    <= '0;
            r_period_reg      <= '0;
            r_length_enable   <= 1'b0;
            r_power_on        <= 1'b0;
            r_volume          <= '0;
            r_env_pace        <= '0;
            r_env_up          <= 1'b0;
            r_duty            <= '0;
            r_length          <= '0;
            r_running         <= 1'b0;
            r_period          <= '0;
            r_work            <= 1'b0;
            r_out_valid       <= 1'b0;
            r_out             <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SWEEP:       r_sweep_reg       <= i_cfg_data[6:0];
                    REG_DUTY_LENGTH: r_duty_length_reg <= i_cfg_data[7:0];
                    REG_ENVELOPE:    r_envelope_reg    <= i_cfg_data[7:0];
                    REG_PERIOD:      r_period_reg      <= i_cfg_data;
                    REG_LENGTH_EN:   r_length_enable   <= i_cfg_data[0];
                    REG_POWER:       r_power_on        <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_work  <= r_power_on && n_dac_on;
                        r_state <= S_ENV_DIV;
                        if (r_power_on && !n_dac_on) begin
                            r_running <= 1'b0;
                        end else if (r_power_on) begin
                            r_running <= n_running;
                            r_length  <= n_length;
                            r_env_pace <= n_pace;
                            if (i_data.trigger) begin
                                r_duty   <= duty_eighths_of(r_duty_length_reg[7:6]);
                                r_volume <= r_envelope_reg[7:4];
                                r_env_up <= r_envelope_reg[3];
                                r_period <= r_period_reg;
                            end
                        end
                    end
                end
                S_ENV_DIV: begin
                    if (r_cnt == 3'd7) begin
                        r_state <= S_ENV_APPLY;
                    end
                end
                S_ENV_APPLY: begin
                    r_state <= S_SWP_DIV;
                    if (r_work && r_env_pace != '0 && r_item.envelope_tick
                            && r_running && r_rem == '0) begin
                        if (r_env_up) begin
                            if (r_volume < VolumeMax) begin
                                r_volume <= r_volume + 4'd1;
                            end
                        end else if (r_volume != 4'd0) begin
                            r_volume <= r_volume - 4'd1;
                        end
                    end
                end
                S_SWP_DIV: begin
                    if (r_cnt == 3'd7) begin
                        r_state <= S_SWP_APPLY;
                    end
                end
                S_SWP_APPLY: begin
                    r_state <= S_OUT;
                    if (r_work && r_sweep_reg[6:4] != '0 && r_item.sweep_tick
                            && r_rem == '0) begin
                        if (r_sweep_reg[3]) begin
                            r_period <= r_period - n_delta;
                        end else begin
                            if (n_sum[PeriodWidth]) begin
                                r_running <= 1'b0;
                            end
                            r_period <= n_sum[PeriodWidth-1:0];
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out.active       <= r_running;
                        r_out.volume       <= r_volume;
                        r_out.period       <= r_period;
                        r_out.duty_eighths <= r_duty;
                        r_out.length_count <= r_length;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Shared remainder unit: one dividend bit per cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && n_accept) begin
            r_item <= i_data;
            r_dvd  <= i_data.envelope_step;
            r_div  <= (i_data.trigger && r_power_on && n_dac_on)
                      ? r_envelope_reg[2:0] : r_env_pace;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (r_state == S_ENV_APPLY) begin
            r_dvd <= r_item.sweep_step;
            r_div <= r_sweep_reg[6:4];
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_state == S_ENV_DIV || r_state == S_SWP_DIV) begin
            r_dvd <= {r_dvd[StepWidth-2:0], 1'b0};
            r_rem <= n_rem;
            r_cnt <= r_cnt + 3'd1;
        end
    end

endmodule
